FILE: src/sha1bc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha1bc_pkg;

  localparam int WORD_W    = 32;
  localparam int ROUNDS    = 80;
  localparam int WIN_DEPTH = 16;
  localparam int CV_DEPTH  = 5;
  localparam int K_DEPTH   = 4;
  localparam int ROUND_W   = $clog2(ROUNDS);
  localparam int POS_W     = $clog2(WIN_DEPTH);
  localparam int DIG_IDX_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int PH_PAR1_START = 20;
  localparam int PH_MAJ_START  = 40;
  localparam int PH_PAR2_START = 60;

  localparam int ROT_A   = 5;
  localparam int ROT_B   = 30;
  localparam int ROT_EXP = 1;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [ROUND_W-1:0]   ROUND_LAST = ROUND_W'(ROUNDS - 1);
  localparam logic [POS_W-1:0]     POS_LAST   = POS_W'(WIN_DEPTH - 1);
  localparam logic [DIG_IDX_W-1:0] DIG_LAST   = DIG_IDX_W'(CV_DEPTH - 1);

  localparam word_t CV_INIT [CV_DEPTH] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_INIT [K_DEPTH] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef enum logic [1:0] {
    FN_CH,
    FN_PAR,
    FN_MAJ
  } fn_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_FINAL
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K_A,
    CFG_K_B,
    CFG_K_C,
    CFG_K_D
  } cfg_idx_t;

  typedef struct packed {
    fn_t   fn;
    word_t k;
  } round_ctl_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage
`default_nettype wire

FILE: src/sha1bc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sha1bc_in_if import sha1bc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t message_word;
  logic  first_of_message;
  logic  last_of_message;

  modport source (output valid, message_word, first_of_message, last_of_message,
                  input ready);
  modport sink   (input valid, message_word, first_of_message, last_of_message,
                  output ready);
endinterface

interface sha1bc_out_if import sha1bc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  word_t                digest_word;
  logic [DIG_IDX_W-1:0] digest_index;
  logic                 digest_last;

  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

FILE: src/sha1bc_wcell.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1bc_wcell import sha1bc_pkg::*; (
  input  logic  clk,
  input  logic  shift,
  input  word_t d,
  output word_t q
);

  word_t q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

FILE: src/sha1bc_round.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1bc_round import sha1bc_pkg::*; (
  input  word_t      a,
  input  word_t      b,
  input  word_t      c,
  input  word_t      d,
  input  word_t      e,
  input  word_t      wt,
  input  round_ctl_t ctl,
  output word_t      a_new
);

  word_t f;

  always_comb begin
    unique case (ctl.fn)
      FN_CH:   f = (b & c) | (~b & d);
      FN_MAJ:  f = (b & c) | (b & d) | (c & d);
      FN_PAR:  f = b ^ c ^ d;
      default: f = b ^ c ^ d;
    endcase
  end

  assign a_new = rotl(a, ROT_A) + f + e + ctl.k + wt;

endmodule
`default_nettype wire

FILE: src/sha1_block_compressor_top.sv
// SHA-1 compression core. Padded message words are taken one per cycle until
// sixteen form a block; the input then stalls while the single shared round
// unit iterates once per cycle through the rounds, followed by the chaining add.
// The schedule is a row of sixteen word cells shifting once per round, the
// newest cell fed by the rotate-by-1 expansion. A digest is copied to a
// five-word output buffer and drains one word per accepted result while the
// next message is collected; a block that completes another message waits in
// the add cycle until the previous digest has drained.
`timescale 1ns / 1ps
`default_nettype none
module sha1_block_compressor_top import sha1bc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  sha1bc_in_if.sink            in_ch,
  sha1bc_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_wdata
);

  state_t state_r, state_nxt;

  word_t k_r   [K_DEPTH];
  word_t cv_r  [CV_DEPTH];
  word_t dig_r [CV_DEPTH];
  word_t a_r, b_r, c_r, d_r, e_r;
  logic [ROUND_W-1:0]   t_r;
  logic [POS_W-1:0]     pos_r;
  logic [DIG_IDX_W-1:0] idx_r;
  logic                 last_r;
  logic                 busy_r;

  word_t win_q  [WIN_DEPTH];
  word_t win_d  [WIN_DEPTH];
  word_t work   [CV_DEPTH];
  word_t sum    [CV_DEPTH];
  word_t expand;
  word_t a_new;

  round_ctl_t ctl;
  logic [POS_W-1:0] pos_eff;
  logic in_acc, out_acc, win_shift, block_done, final_go;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign pos_eff = in_ch.first_of_message ? '0 : pos_r;
  assign expand  = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], ROT_EXP);

  // schedule cells
  genvar gi;
  generate
    for (gi = 0; gi < WIN_DEPTH; gi++) begin : g_win
      if (gi == WIN_DEPTH - 1) begin : g_tail
        assign win_d[gi] = (state_r == ST_COLLECT) ? in_ch.message_word : expand;
      end else begin : g_body
        assign win_d[gi] = win_q[gi+1];
      end
      sha1bc_wcell u_cell (
        .clk   (clk),
        .shift (win_shift),
        .d     (win_d[gi]),
        .q     (win_q[gi])
      );
    end
  endgenerate

  always_comb begin
    if (t_r < ROUND_W'(PH_PAR1_START)) begin
      ctl.fn = FN_CH;
      ctl.k  = k_r[0];
    end else if (t_r < ROUND_W'(PH_MAJ_START)) begin
      ctl.fn = FN_PAR;
      ctl.k  = k_r[1];
    end else if (t_r < ROUND_W'(PH_PAR2_START)) begin
      ctl.fn = FN_MAJ;
      ctl.k  = k_r[2];
    end else begin
      ctl.fn = FN_PAR;
      ctl.k  = k_r[3];
    end
  end

  sha1bc_round u_round (
    .a     (a_r),
    .b     (b_r),
    .c     (c_r),
    .d     (d_r),
    .e     (e_r),
    .wt    (win_q[0]),
    .ctl   (ctl),
    .a_new (a_new)
  );

  assign work[0] = a_r;
  assign work[1] = b_r;
  assign work[2] = c_r;
  assign work[3] = d_r;
  assign work[4] = e_r;

  always_comb begin
    for (int i = 0; i < CV_DEPTH; i++) begin
      sum[i] = cv_r[i] + work[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc && pos_eff == POS_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (t_r == ROUND_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!(last_r && busy_r)) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    win_shift   = 1'b0;
    block_done  = 1'b0;
    final_go    = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        in_ch.ready = 1'b1;
        win_shift   = in_ch.valid;
        block_done  = in_ch.valid && pos_eff == POS_LAST;
      end
      ST_ROUND: begin
        win_shift = 1'b1;
      end
      ST_FINAL: begin
        final_go = !(last_r && busy_r);
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = busy_r;
  assign out_ch.digest_word  = dig_r[0];
  assign out_ch.digest_index = idx_r;
  assign out_ch.digest_last  = idx_r == DIG_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      pos_r   <= '0;
      busy_r  <= 1'b0;
      for (int i = 0; i < CV_DEPTH; i++) begin
        cv_r[i] <= CV_INIT[i];
      end
      for (int i = 0; i < K_DEPTH; i++) begin
        k_r[i] <= K_INIT[i];
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_K_A: k_r[0] <= cfg_wdata;
          CFG_K_B: k_r[1] <= cfg_wdata;
          CFG_K_C: k_r[2] <= cfg_wdata;
          CFG_K_D: k_r[3] <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc) begin
        pos_r <= pos_eff + POS_W'(1);
        if (in_ch.first_of_message) begin
          for (int i = 0; i < CV_DEPTH; i++) begin
            cv_r[i] <= CV_INIT[i];
          end
        end
      end

      if (final_go) begin
        for (int i = 0; i < CV_DEPTH; i++) begin
          cv_r[i] <= sum[i];
        end
      end

      if (final_go && last_r) begin
        busy_r <= 1'b1;
      end else if (out_acc && idx_r == DIG_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // round datapath and digest buffer
  always_ff @(posedge clk) begin
    if (block_done) begin
      a_r    <= cv_r[0];
      b_r    <= cv_r[1];
      c_r    <= cv_r[2];
      d_r    <= cv_r[3];
      e_r    <= cv_r[4];
      t_r    <= '0;
      last_r <= in_ch.last_of_message;
    end else if (state_r == ST_ROUND) begin
      a_r <= a_new;
      b_r <= a_r;
      c_r <= rotl(b_r, ROT_B);
      d_r <= c_r;
      e_r <= d_r;
      t_r <= t_r + ROUND_W'(1);
    end

    if (final_go && last_r) begin
      for (int i = 0; i < CV_DEPTH; i++) begin
        dig_r[i] <= sum[i];
      end
      idx_r <= '0;
    end else if (out_acc) begin
      for (int i = 0; i < CV_DEPTH - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
      idx_r <= idx_r + DIG_IDX_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: src/sha1bc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1bc_chk import sha1bc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DIG_IDX_W-1:0] digest_index,
  input logic                 digest_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !digest_last |=>
      out_valid && digest_index == $past(digest_index) + DIG_IDX_W'(1))
    else $error("digest burst broken or out of order");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (digest_last == (digest_index == DIG_LAST)))
    else $error("digest_last does not match final index");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> digest_index <= DIG_LAST)
    else $error("digest index out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sha1_block_compressor_top sha1bc_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .digest_index (out_ch.digest_index),
  .digest_last  (out_ch.digest_last)
);
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sha1bc_pkg::*;

  typedef struct {
    word_t word;
    bit    first;
    bit    last;
  } msg_word_t;

  typedef struct {
    word_t                word;
    logic [DIG_IDX_W-1:0] index;
    bit                   last;
  } digest_t;

  localparam word_t SHA1_IV [CV_DEPTH] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam word_t K_STD_A = 32'h5A827999;
  localparam word_t K_STD_B = 32'h6ED9EBA1;
  localparam word_t K_STD_C = 32'h8F1BBCDC;
  localparam word_t K_STD_D = 32'hCA62C1D6;
  localparam int    SETTLE_CYCLES = 150;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_wdata;

  sha1bc_in_if  in_ch ();
  sha1bc_out_if out_ch ();

  sha1_block_compressor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  msg_word_t words_pending [$];
  digest_t   digests_due [$];

  word_t            chain [CV_DEPTH];
  word_t            sched [WIN_DEPTH];
  logic [POS_W-1:0] wpos;
  word_t            round_k [K_DEPTH];

  bit failed;
  bit stall_en;
  int src_gap;
  int sink_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor: one sha-1 compression of the collected block into the chaining value
  function automatic void compress_block();
    word_t w [WIN_DEPTH];
    word_t a, b, c, d, e, f, k, x, tmp;
    w = sched;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int t = 0; t < ROUNDS; t++) begin
      if (t >= WIN_DEPTH) begin
        x = w[(t - 3) % WIN_DEPTH] ^ w[(t - 8) % WIN_DEPTH] ^
            w[(t - 14) % WIN_DEPTH] ^ w[t % WIN_DEPTH];
        w[t % WIN_DEPTH] = {x[30:0], x[31]};
      end
      if (t < PH_PAR1_START) begin
        f = (b & c) | (~b & d);
        k = round_k[CFG_K_A];
      end else if (t < PH_MAJ_START) begin
        f = b ^ c ^ d;
        k = round_k[CFG_K_B];
      end else if (t < PH_PAR2_START) begin
        f = (b & c) | (b & d) | (c & d);
        k = round_k[CFG_K_C];
      end else begin
        f = b ^ c ^ d;
        k = round_k[CFG_K_D];
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + w[t % WIN_DEPTH];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void absorb_word(word_t w, bit first, bit last);
    digest_t dg;
    if (first) begin
      chain = SHA1_IV;
      wpos = '0;
    end
    sched[wpos] = w;
    if (wpos != POS_LAST) begin
      wpos = wpos + 1'b1;
      return;
    end
    wpos = '0;
    compress_block();
    if (!last) return;
    for (int i = 0; i < CV_DEPTH; i++) begin
      dg.word = chain[i];
      dg.index = DIG_IDX_W'(i);
      dg.last = (i == CV_DEPTH - 1);
      digests_due.push_back(dg);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    msg_word_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        absorb_word(in_ch.message_word, in_ch.first_of_message, in_ch.last_of_message);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (words_pending.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (stall_en && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 17) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          it = words_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.message_word <= it.word;
          in_ch.first_of_message <= it.first;
          in_ch.last_of_message <= it.last;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_t exp_d;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digests_due.size() == 0) begin
        $error("unexpected digest item: word %h index %0d last %0d",
               out_ch.digest_word, out_ch.digest_index, out_ch.digest_last);
        failed = 1'b1;
      end else begin
        exp_d = digests_due.pop_front();
        if (out_ch.digest_word !== exp_d.word) begin
          $error("digest_word: expected %h, actual %h", exp_d.word, out_ch.digest_word);
          failed = 1'b1;
        end
        if (out_ch.digest_index !== exp_d.index) begin
          $error("digest_index: expected %0d, actual %0d", exp_d.index, out_ch.digest_index);
          failed = 1'b1;
        end
        if (out_ch.digest_last !== exp_d.last) begin
          $error("digest_last: expected %0d, actual %0d", exp_d.last, out_ch.digest_last);
          failed = 1'b1;
        end
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(1, 17) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, word_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    round_k[idx] = val;
  endtask

  task automatic set_round_consts(word_t ka, word_t kb, word_t kc, word_t kd);
    write_reg(CFG_K_A, ka);
    write_reg(CFG_K_B, kb);
    write_reg(CFG_K_C, kc);
    write_reg(CFG_K_D, kd);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block has drained everything and finished any compression in flight
  task automatic settle();
    do @(posedge clk);
    while (words_pending.size() != 0 || in_ch.valid || digests_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_word(word_t w, bit first, bit last);
    msg_word_t it;
    it.word = w;
    it.first = first;
    it.last = last;
    words_pending.push_back(it);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_message(int blocks, bit fresh);
    for (int i = 0; i < blocks * WIN_DEPTH; i++)
      queue_word(rand_word(), fresh && i == 0, i == blocks * WIN_DEPTH - 1);
  endfunction

  function automatic void queue_random(int count);
    int added;
    int n;
    int kind;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        n = ($urandom_range(0, 3) == 0) ? 2 : 1;
        queue_message(n, 1'b1);
        added += n * WIN_DEPTH;
      end else if (kind == 6) begin
        // keeps chaining from the previous digest
        queue_message(1, 1'b0);
        added += WIN_DEPTH;
      end else if (kind == 7) begin
        // truncated message, dropped by the next first flag
        n = $urandom_range(1, WIN_DEPTH - 1);
        for (int i = 0; i < n; i++)
          queue_word(rand_word(), i == 0, $urandom_range(0, 3) == 0);
        added += n;
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          queue_word(rand_word(), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
        added += n;
      end
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_K_A;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.message_word = '0;
    in_ch.first_of_message = 1'b0;
    in_ch.last_of_message = 1'b0;
    out_ch.ready = 1'b0;
    failed = 1'b0;
    stall_en = 1'b1;
    src_gap = 0;
    sink_hold = 0;
    chain = SHA1_IV;
    for (int i = 0; i < WIN_DEPTH; i++) sched[i] = '0;
    wpos = '0;
    round_k[CFG_K_A] = K_STD_A;
    round_k[CFG_K_B] = K_STD_B;
    round_k[CFG_K_C] = K_STD_C;
    round_k[CFG_K_D] = K_STD_D;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // partial block with last flags, then abc restarted mid-block
    queue_word('1, 1'b1, 1'b1);
    queue_word('0, 1'b0, 1'b0);
    queue_word(32'h80000000, 1'b0, 1'b1);
    for (int i = 0; i < WIN_DEPTH; i++)
      queue_word(i == 0 ? 32'h61626380 : (i == WIN_DEPTH - 1 ? 32'h00000018 : '0),
                 i == 0, i == 7 || i == WIN_DEPTH - 1);
    queue_random(80);
    settle();

    set_round_consts('0, '0, '0, '0);
    @(negedge clk);
    queue_random(60);
    settle();

    set_round_consts('1, '1, '1, '1);
    @(negedge clk);
    queue_random(60);
    settle();

    set_round_consts($urandom(), $urandom(), $urandom(), $urandom());
    @(negedge clk);
    queue_random(60);
    settle();

    set_round_consts(K_STD_A, K_STD_B, K_STD_C, K_STD_D);
    stall_en <= 1'b0;
    @(negedge clk);
    queue_random(60);
    settle();

    if (!failed)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
